FILE: hdl/esppid_pkg.sv
// Shared widths, codes and control types for the encoder speed PID block.
`default_nettype none
package esppid_pkg;

    localparam int PERIOD_W   = 24;
    localparam int TGT_W      = 20;
    localparam int GAIN_W     = 16;
    localparam int WINDUP_W   = 24;
    localparam int PWM_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int COUNTS_PER_REV_DEF = 1024;
    localparam int PWM_MAX_DEF        = 4095;

    // 60e6 * 16, the speed numerator in Q.4 rpm
    localparam int                NUM_W     = 30;
    localparam logic [NUM_W-1:0]  SPEED_NUM = 30'd960000000;
    localparam logic [NUM_W-1:0]  SPEED_MAX = 30'd1048575;
    localparam int                CNT_W     = $clog2(NUM_W);
    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(NUM_W - 1);

    localparam int ERR_W  = 22;
    localparam int DER_W  = 23;
    localparam int INT_W  = 32;
    localparam int PROD_W = GAIN_W + INT_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SHIFT  = 12;
    localparam int CORR_W = ACC_W - SHIFT;
    localparam int LVL_W  = CORR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP     = 2'd0,
        CFG_KI     = 2'd1,
        CFG_KD     = 2'd2,
        CFG_WINDUP = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MSEL_P = 2'd0,
        MSEL_I = 2'd1,
        MSEL_D = 2'd2
    } t_msel;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } t_acc_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SPEED,
        ST_INTEG,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_ROUND,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    div_step;
        logic    speed;
        logic    integ;
        logic    mul_en;
        t_msel   mul_sel;
        t_acc_op acc_op;
        logic    round;
        logic    update;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_sts;

endpackage
`default_nettype wire

FILE: hdl/esppid_ctrl.sv
// Sequencer for the speed divide, PID terms and PWM update.
`default_nettype none
module esppid_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  esppid_pkg::t_sts    i_sts,
    output esppid_pkg::t_cmd    o_cmd
);

    esppid_pkg::t_state                 r_state, n_state;
    logic [esppid_pkg::CNT_W-1:0]       r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esppid_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            esppid_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (i_valid) n_state = esppid_pkg::ST_DIV;
            end
            esppid_pkg::ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == esppid_pkg::DIV_LAST) n_state = esppid_pkg::ST_SPEED;
            end
            esppid_pkg::ST_SPEED:  n_state = esppid_pkg::ST_INTEG;
            esppid_pkg::ST_INTEG:  n_state = esppid_pkg::ST_MUL_P;
            esppid_pkg::ST_MUL_P:  n_state = esppid_pkg::ST_MUL_I;
            esppid_pkg::ST_MUL_I:  n_state = esppid_pkg::ST_MUL_D;
            esppid_pkg::ST_MUL_D:  n_state = esppid_pkg::ST_ACC;
            esppid_pkg::ST_ACC:    n_state = esppid_pkg::ST_ROUND;
            esppid_pkg::ST_ROUND:  n_state = esppid_pkg::ST_UPDATE;
            esppid_pkg::ST_UPDATE: begin
                if (!i_sts.out_full) n_state = esppid_pkg::ST_IDLE;
            end
            default: n_state = esppid_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = 1'b0;
        o_cmd          = '0;
        o_cmd.mul_sel  = esppid_pkg::MSEL_P;
        o_cmd.acc_op   = esppid_pkg::ACC_HOLD;
        unique case (r_state)
            esppid_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            esppid_pkg::ST_DIV:   o_cmd.div_step = 1'b1;
            esppid_pkg::ST_SPEED: o_cmd.speed    = 1'b1;
            esppid_pkg::ST_INTEG: o_cmd.integ    = 1'b1;
            esppid_pkg::ST_MUL_P: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = esppid_pkg::MSEL_P;
            end
            esppid_pkg::ST_MUL_I: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = esppid_pkg::MSEL_I;
                o_cmd.acc_op  = esppid_pkg::ACC_LOAD;
            end
            esppid_pkg::ST_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = esppid_pkg::MSEL_D;
                o_cmd.acc_op  = esppid_pkg::ACC_ADD;
            end
            esppid_pkg::ST_ACC:    o_cmd.acc_op = esppid_pkg::ACC_ADD;
            esppid_pkg::ST_ROUND:  o_cmd.round  = 1'b1;
            esppid_pkg::ST_UPDATE: o_cmd.update = !i_sts.out_full;
            default: o_ready = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/esppid_dp.sv
// Datapath: serial speed divider, shared PID multiplier, PWM level and output beat.
`default_nettype none
module esppid_dp #(
    parameter int COUNTS_PER_REV = esppid_pkg::COUNTS_PER_REV_DEF,
    parameter int PWM_MAX        = esppid_pkg::PWM_MAX_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  esppid_pkg::t_cmd                     i_cmd,
    output esppid_pkg::t_sts                     o_sts,
    input  wire                                  i_cfg_valid,
    input  wire [esppid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [esppid_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire [esppid_pkg::PERIOD_W-1:0]       i_period_us,
    input  wire [esppid_pkg::TGT_W-1:0]          i_target_speed,
    input  wire                                  i_direction,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [esppid_pkg::PWM_W-1:0]         o_pwm_out,
    output logic                                 o_direction_out
);

    localparam int DEN_W = esppid_pkg::PERIOD_W + $clog2(COUNTS_PER_REV + 1);
    localparam int CEIL  = (PWM_MAX < 4095) ? PWM_MAX : 4095;
    localparam int NW    = esppid_pkg::NUM_W;
    localparam int EW    = esppid_pkg::ERR_W;
    localparam int DW    = esppid_pkg::DER_W;
    localparam int IW    = esppid_pkg::INT_W;
    localparam int PW    = esppid_pkg::PROD_W;
    localparam int AW    = esppid_pkg::ACC_W;
    localparam int CW    = esppid_pkg::CORR_W;
    localparam int LW    = esppid_pkg::LVL_W;
    localparam int GW    = esppid_pkg::GAIN_W;

    // configuration
    logic signed [GW-1:0]                      r_kp, r_ki, r_kd;
    logic [esppid_pkg::WINDUP_W-1:0]           r_windup;

    // item and working registers
    logic [DEN_W-1:0]                          r_den;
    logic [DEN_W-1:0]                          r_rem;
    logic [NW-1:0]                             r_quo;
    logic [esppid_pkg::TGT_W-1:0]              r_tgt;
    logic                                      r_dir;
    logic signed [EW-1:0]                      r_err;
    logic signed [DW-1:0]                      r_deriv;
    logic signed [PW-1:0]                      r_prod;
    logic signed [AW-1:0]                      r_acc;
    logic signed [CW-1:0]                      r_corr;

    // loop state and output beat
    logic signed [IW-1:0]                      r_int;
    logic signed [EW-1:0]                      r_prev;
    logic [esppid_pkg::PWM_W-1:0]              r_pwm;
    logic                                      r_dout;
    logic                                      r_out_valid;

    logic [DEN_W:0]                            rem_sh;
    logic                                      q_bit;
    logic [DEN_W-1:0]                          rem_nx;
    logic [esppid_pkg::TGT_W-1:0]              speed;
    logic [IW-1:0]                             int_mag;
    logic signed [GW-1:0]                      mul_a;
    logic signed [IW-1:0]                      mul_b;
    logic signed [AW-1:0]                      adj;
    logic signed [LW-1:0]                      lvl;
    logic [esppid_pkg::PWM_W-1:0]              lvl_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= '0;
            r_ki     <= '0;
            r_kd     <= '0;
            r_windup <= '0;
        end else if (i_cfg_valid) begin
            unique case (esppid_pkg::t_cfg_idx'(i_cfg_index))
                esppid_pkg::CFG_KP:     r_kp     <= i_cfg_data[GW-1:0];
                esppid_pkg::CFG_KI:     r_ki     <= i_cfg_data[GW-1:0];
                esppid_pkg::CFG_KD:     r_kd     <= i_cfg_data[GW-1:0];
                esppid_pkg::CFG_WINDUP: r_windup <= i_cfg_data;
                default:                r_windup <= r_windup;
            endcase
        end
    end

    // restoring divide, one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[NW-1]};
        q_bit  = (rem_sh >= {1'b0, r_den});
        rem_nx = q_bit ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
    end

    always_comb begin
        if (r_den == '0)
            speed = '0;
        else if (r_quo > esppid_pkg::SPEED_MAX)
            speed = esppid_pkg::SPEED_MAX[esppid_pkg::TGT_W-1:0];
        else
            speed = r_quo[esppid_pkg::TGT_W-1:0];
    end

    assign int_mag = r_int[IW-1] ? IW'(-r_int) : IW'(r_int);

    always_comb begin
        unique case (i_cmd.mul_sel)
            esppid_pkg::MSEL_P: begin
                mul_a = r_kp;
                mul_b = IW'(r_err);
            end
            esppid_pkg::MSEL_I: begin
                mul_a = r_ki;
                mul_b = r_int;
            end
            esppid_pkg::MSEL_D: begin
                mul_a = r_kd;
                mul_b = IW'(r_deriv);
            end
            default: begin
                mul_a = r_kp;
                mul_b = IW'(r_err);
            end
        endcase
    end

    assign adj = r_acc + (r_acc[AW-1] ? AW'((1 << esppid_pkg::SHIFT) - 1) : AW'(0));
    assign lvl = LW'($signed({1'b0, r_pwm})) + LW'(r_corr);

    always_comb begin
        if (lvl < 0)
            lvl_clamped = '0;
        else if (lvl > $signed(LW'(CEIL)))
            lvl_clamped = esppid_pkg::PWM_W'(CEIL);
        else
            lvl_clamped = lvl[esppid_pkg::PWM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_den <= DEN_W'(i_period_us) * DEN_W'(COUNTS_PER_REV);
            r_rem <= '0;
            r_quo <= esppid_pkg::SPEED_NUM;
            r_tgt <= i_target_speed;
            r_dir <= i_direction;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_nx;
            r_quo <= {r_quo[NW-2:0], q_bit};
        end
        if (i_cmd.speed)
            r_err <= $signed(EW'(r_tgt)) - $signed(EW'(speed));
        if (i_cmd.integ)
            r_deriv <= DW'(r_err) - DW'(r_prev);
        if (i_cmd.mul_en)
            r_prod <= mul_a * mul_b;
        unique case (i_cmd.acc_op)
            esppid_pkg::ACC_HOLD: r_acc <= r_acc;
            esppid_pkg::ACC_LOAD: r_acc <= AW'(r_prod);
            esppid_pkg::ACC_ADD:  r_acc <= r_acc + AW'(r_prod);
            default:              r_acc <= r_acc;
        endcase
        if (i_cmd.round)
            r_corr <= adj[AW-1:esppid_pkg::SHIFT];
        if (i_cmd.update)
            r_dout <= r_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int       <= '0;
            r_prev      <= '0;
            r_pwm       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.integ) begin
                if (int_mag < IW'(r_windup))
                    r_int <= r_int + IW'(r_err);
                else
                    r_int <= '0;
                r_prev <= r_err;
            end
            if (i_cmd.update) begin
                r_pwm       <= lvl_clamped;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_full  = r_out_valid && !i_ready;
    assign o_valid         = r_out_valid;
    assign o_pwm_out       = r_pwm;
    assign o_direction_out = r_dout;

endmodule
`default_nettype wire

FILE: hdl/encoder_speed_pid_pwm.sv
// Top level: encoder period to speed, incremental PID and clamped PWM level.
// The input is accepted only in the idle state, so one item runs through the serial speed divider
// and the PID steps before the next is taken; a stalled result beat holds the update.
// The PID terms share one 16x32 multiplier, used in turn for the P, I and D terms.
// Synchronous active-low reset clears gains, windup limit, integral,
// previous error and PWM level; no clearing pass is needed.
`default_nettype none
module encoder_speed_pid_pwm #(
    parameter int COUNTS_PER_REV = esppid_pkg::COUNTS_PER_REV_DEF,
    parameter int PWM_MAX        = esppid_pkg::PWM_MAX_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire [esppid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [esppid_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire [esppid_pkg::PERIOD_W-1:0]       i_period_us,
    input  wire [esppid_pkg::TGT_W-1:0]          i_target_speed,
    input  wire                                  i_direction,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [esppid_pkg::PWM_W-1:0]         o_pwm_out,
    output logic                                 o_direction_out
);

    esppid_pkg::t_cmd cmd;
    esppid_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    esppid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    esppid_dp #(
        .COUNTS_PER_REV (COUNTS_PER_REV),
        .PWM_MAX        (PWM_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_period_us     (i_period_us),
        .i_target_speed  (i_target_speed),
        .i_direction     (i_direction),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pwm_out       (o_pwm_out),
        .o_direction_out (o_direction_out)
    );

endmodule
`default_nettype wire

FILE: bench/pwm_loop_checker.sv
// Checker for the encoder speed PID block: tracks gains, predicts PWM beats, compares.
module pwm_loop_checker #(
    parameter int COUNTS_PER_REV = esppid_pkg::COUNTS_PER_REV_DEF,
    parameter int PWM_MAX        = esppid_pkg::PWM_MAX_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              cfg_valid,
    input  wire                              cfg_ready,
    input  wire [esppid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [esppid_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire                              in_valid,
    input  wire                              in_ready,
    input  wire [esppid_pkg::PERIOD_W-1:0]   period_us,
    input  wire [esppid_pkg::TGT_W-1:0]      target_speed,
    input  wire                              direction,
    input  wire                              out_valid,
    input  wire                              out_ready,
    input  wire [esppid_pkg::PWM_W-1:0]      pwm_out,
    input  wire                              direction_out,
    output int                               o_pending,
    output int                               o_fail_count
);
    import esppid_pkg::*;

    localparam longint RPM_SCALE = 64'd960000000;
    localparam longint RPM_CEIL  = 64'd1048575;
    localparam longint DUTY_CEIL = (PWM_MAX < 4095) ? PWM_MAX : 4095;

    typedef struct packed {
        logic [PWM_W-1:0] duty;
        logic             dir;
    } t_duty_beat;

    longint     gain_p, gain_i, gain_d, windup;
    longint     integ, prev_err, duty_level;
    t_duty_beat duty_q[$];
    int         fails = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        fails++;
    endtask

    // One control-loop update; pushes the PWM beat it should produce.
    task automatic step_controller(input logic [PERIOD_W-1:0] period,
                                   input logic [TGT_W-1:0] target, input logic dir);
        longint     rpm;
        longint     err;
        longint     deriv;
        longint     sum;
        longint     corr;
        t_duty_beat beat;
        rpm = 0;
        if (period != 0) begin
            rpm = RPM_SCALE / (longint'(period) * COUNTS_PER_REV);
            if (rpm > RPM_CEIL) rpm = RPM_CEIL;
        end
        err = longint'(target) - rpm;
        if (((integ < 0) ? -integ : integ) < windup) begin
            integ += err;
        end else begin
            integ = 0;
        end
        deriv    = err - prev_err;
        prev_err = err;
        sum  = gain_p * err + gain_i * integ + gain_d * deriv;
        corr = (sum < 0) ? -((-sum) >>> SHIFT) : (sum >>> SHIFT);
        duty_level += corr;
        if (duty_level < 0) duty_level = 0;
        if (duty_level > DUTY_CEIL) duty_level = DUTY_CEIL;
        beat.duty = duty_level[PWM_W-1:0];
        beat.dir  = dir;
        duty_q.push_back(beat);
    endtask

    always @(posedge i_clk) begin
        t_duty_beat want;
        if (!i_rst_n) begin
            gain_p     = 0;
            gain_i     = 0;
            gain_d     = 0;
            windup     = 0;
            integ      = 0;
            prev_err   = 0;
            duty_level = 0;
            duty_q.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (duty_q.size() == 0) begin
                    report_mismatch($sformatf("pwm beat %0d with nothing expected", pwm_out));
                end else begin
                    want = duty_q.pop_front();
                    if (pwm_out !== want.duty)
                        report_mismatch($sformatf("pwm_out got %0d expected %0d",
                                                  pwm_out, want.duty));
                    if (direction_out !== want.dir)
                        report_mismatch($sformatf("direction_out got %0b expected %0b",
                                                  direction_out, want.dir));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (t_cfg_idx'(cfg_index))
                    CFG_KP:     gain_p = longint'($signed(cfg_data[GAIN_W-1:0]));
                    CFG_KI:     gain_i = longint'($signed(cfg_data[GAIN_W-1:0]));
                    CFG_KD:     gain_d = longint'($signed(cfg_data[GAIN_W-1:0]));
                    CFG_WINDUP: windup = longint'(cfg_data[WINDUP_W-1:0]);
                    default: ;
                endcase
            end
            if (in_valid && in_ready) step_controller(period_us, target_speed, direction);
        end
        o_pending    <= duty_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: bench/tb_top.sv
// Testbench top: drives encoder samples and gain settings into the PID block, gives the verdict.
module tb_top;
    import esppid_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int TAIL_CYCLES   = 60;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS   = 92;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [PERIOD_W-1:0]   i_period_us;
    logic [TGT_W-1:0]      i_target_speed;
    logic                  i_direction;
    logic                  o_valid;
    logic                  i_ready = 1'b1;
    logic [PWM_W-1:0]      o_pwm_out;
    logic                  o_direction_out;

    int          pending;
    int          fail_count;
    bit          src_idle = 1'b0;
    bit          sink_idle = 1'b0;
    int unsigned sink_hold = 0;
    int unsigned cycles = 0;

    encoder_speed_pid_pwm #(
        .COUNTS_PER_REV(COUNTS_PER_REV_DEF),
        .PWM_MAX       (PWM_MAX_DEF)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_period_us    (i_period_us),
        .i_target_speed (i_target_speed),
        .i_direction    (i_direction),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pwm_out      (o_pwm_out),
        .o_direction_out(o_direction_out)
    );

    pwm_loop_checker #(
        .COUNTS_PER_REV(COUNTS_PER_REV_DEF),
        .PWM_MAX       (PWM_MAX_DEF)
    ) watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cfg_valid    (i_cfg_valid),
        .cfg_ready    (o_cfg_ready),
        .cfg_index    (i_cfg_index),
        .cfg_data     (i_cfg_data),
        .in_valid     (i_valid),
        .in_ready     (o_ready),
        .period_us    (i_period_us),
        .target_speed (i_target_speed),
        .direction    (i_direction),
        .out_valid    (o_valid),
        .out_ready    (i_ready),
        .pwm_out      (o_pwm_out),
        .direction_out(o_direction_out),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // random result-side backpressure, in bursts
    always @(negedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (sink_idle && $urandom_range(0, 5) == 0) begin
            i_ready   <= 1'b0;
            sink_hold <= $urandom_range(0, 15);
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [PERIOD_W-1:0] period,
                               input logic [TGT_W-1:0] target, input logic dir);
        int unsigned gap;
        if (src_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_period_us    <= period;
        i_target_speed <= target;
        i_direction    <= dir;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // hold off the sample channel until every PWM beat is back
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic reconfigure(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                               input logic [GAIN_W-1:0] kd,
                               input logic [WINDUP_W-1:0] wu);
        settle();
        write_reg(CFG_KP, {8'($urandom), kp});
        write_reg(CFG_KI, {8'($urandom), ki});
        write_reg(CFG_KD, {8'($urandom), kd});
        write_reg(CFG_WINDUP, wu);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [PERIOD_W-1:0] period;
        logic [TGT_W-1:0]    target;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_KP;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_period_us    = '0;
        i_target_speed = '0;
        i_direction    = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle = 1'b1;
        sink_idle <= 1'b1;
        reconfigure(16'h0100, 16'h0020, 16'h0080, 24'h000100);
        send_sample(24'd0, 20'd0, 1'b0);
        send_sample(24'd0, 20'hFFFFF, 1'b1);          // full error, duty pegs high
        send_sample(24'hFFFFFF, 20'hFFFFF, 1'b0);
        send_sample(24'd1, 20'd0, 1'b1);              // fastest speed, duty drops to 0
        send_sample(24'd1, 20'hFFFFF, 1'b0);
        send_sample(24'hAAAAAA, 20'h55555, 1'b1);
        send_sample(24'h555555, 20'hAAAAA, 1'b0);
        repeat (6) send_sample(24'd1000, 20'd1000, 1'b1);  // integral hits windup, clears
        send_sample(24'd937, 20'd1000, 1'b0);         // error near zero
        send_sample(24'd1875, 20'd0, 1'b1);
        send_sample(24'd915, 20'd1024, 1'b0);
        // zero windup keeps the integral at 0
        reconfigure(16'hFF00, 16'h7FFF, 16'h8000, 24'h000000);
        send_sample(24'd2000, 20'd100, 1'b1);
        send_sample(24'd500, 20'd3000, 1'b0);
        send_sample(24'd0, 20'd50, 1'b1);
        send_sample(24'd30000, 20'd0, 1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: reconfigure(16'h7FFF, 16'h8000, 16'h7FFF, 24'hFFFFFF);
                1: reconfigure(16'h8000, 16'h7FFF, 16'h8000, 24'h000000);
                2: reconfigure(16'h0000, 16'h0000, 16'h0000, 24'($urandom));
                default: reconfigure(16'($urandom_range(0, 1023) - 512),
                                     16'($urandom_range(0, 255) - 128),
                                     16'($urandom_range(0, 511) - 256),
                                     24'($urandom_range(0, 20000)));
            endcase
            src_idle = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_idle <= (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                case ($urandom_range(0, 7))
                    0: period = '0;
                    1: period = PERIOD_W'($urandom_range(1, 16));
                    2: period = PERIOD_W'($urandom);
                    default: period = PERIOD_W'($urandom_range(900, 60000));
                endcase
                case ($urandom_range(0, 5))
                    0: target = '0;
                    1: target = '1;
                    2: target = TGT_W'($urandom);
                    default: target = TGT_W'($urandom_range(0, 2000));
                endcase
                send_sample(period, target, 1'($urandom_range(0, 1)));
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
